// ===== hdl/huffman_tree_decoder_core_defines.svh =====
// Assertion macros shared by the Huffman decoder checkers.
`ifndef HUFFMAN_TREE_DECODER_CORE_DEFINES_SVH
`define HUFFMAN_TREE_DECODER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk and quiet while reset is held.
`define HTD_ASSERT_IMPLY(name, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and quiet while reset is held.
`define HTD_ASSERT_NEXT(name, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// ===== hdl/htd_pkg.sv =====
// Types, constants and the sequencer control store of the Huffman decoder.
package htd_pkg;

	// Fixed field widths of the channels.
	localparam int NODE_IDX_W = 9;
	localparam int SYM_W      = 8;
	localparam int BYTE_W     = 8;
	localparam int CNT_W      = 4;

	localparam logic [CNT_W-1:0]      BITS_MAX   = CNT_W'(BYTE_W);
	localparam logic [NODE_IDX_W-1:0] NULL_CHILD = '0;

	// Sequencer steps.
	typedef enum logic [1:0] {
		STEP_FETCH,
		STEP_WALK,
		STEP_FLUSH
	} step_t;

	// Jump conditions of a control word.
	typedef enum logic [1:0] {
		JMP_ON_DECODE,
		JMP_ON_DONE,
		JMP_ON_FLUSHED,
		JMP_ALWAYS
	} jump_t;

	// One control word of the program.
	typedef struct packed {
		logic  take_item;
		logic  walk;
		logic  flush;
		jump_t jmp;
		step_t target;
	} uword_t;

	// Control store: fetch an item, walk its bits, release the held result.
	function automatic uword_t ucode_rom(step_t step);
		uword_t w;
		case (step)
			STEP_FETCH: begin
				w = '{take_item: 1'b1, walk: 1'b0, flush: 1'b0,
					jmp: JMP_ON_DECODE, target: STEP_WALK};
			end
			STEP_WALK: begin
				w = '{take_item: 1'b0, walk: 1'b1, flush: 1'b0,
					jmp: JMP_ON_DONE, target: STEP_FLUSH};
			end
			STEP_FLUSH: begin
				w = '{take_item: 1'b0, walk: 1'b0, flush: 1'b1,
					jmp: JMP_ON_FLUSHED, target: STEP_FETCH};
			end
			default: begin
				w = '{take_item: 1'b0, walk: 1'b0, flush: 1'b0,
					jmp: JMP_ALWAYS, target: STEP_FETCH};
			end
		endcase
		return w;
	endfunction

endpackage

// ===== hdl/htd_if.sv =====
// Valid/ready channel interfaces for the code input and the result output.
interface htd_code_if import htd_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic                  mode;
	logic [NODE_IDX_W-1:0] node_index;
	logic [NODE_IDX_W-1:0] left_child;
	logic [NODE_IDX_W-1:0] right_child;
	logic                  is_leaf;
	logic [SYM_W-1:0]      leaf_symbol;
	logic [BYTE_W-1:0]     code_byte;
	logic [CNT_W-1:0]      bits_used;

	modport source (
		output valid, mode, node_index, left_child, right_child, is_leaf,
			leaf_symbol, code_byte, bits_used,
		input  ready
	);
	modport sink (
		input  valid, mode, node_index, left_child, right_child, is_leaf,
			leaf_symbol, code_byte, bits_used,
		output ready
	);
endinterface

interface htd_result_if import htd_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [SYM_W-1:0] symbol;
	logic             last;
	logic             error;

	modport source (output valid, symbol, last, error, input ready);
	modport sink (input valid, symbol, last, error, output ready);
endinterface

// ===== hdl/htd_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module htd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port; the data holds while no read is enabled.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hdl/huffman_tree_decoder_core.sv =====
// Huffman tree decoder core: node table, microcoded walk sequencer and result registers.
// A table write item leaves the sequencer in the fetch step, ready for the next item. A decode item walks
// its bits_used code bits through the registered node table read (a read per code bit, one more
// check per leaf); result stalls hold the walk.
// A result shows once the next one of its item is found; the last one after the flush step.
// Reset returns the walk to the root and empties the result registers; the table is not cleared.
module huffman_tree_decoder_core import htd_pkg::*; #(
	parameter int NODE_COUNT  = 512,
	parameter int SYMBOL_BITS = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	htd_code_if.sink      code,
	htd_result_if.source  result
);

	localparam int AW        = $clog2(NODE_COUNT);
	localparam int LEAF_BIT  = SYMBOL_BITS;
	localparam int RIGHT_LSB = SYMBOL_BITS + 1;
	localparam int LEFT_LSB  = RIGHT_LSB + NODE_IDX_W;
	localparam int ENTRY_W   = LEFT_LSB + NODE_IDX_W;

	step_t  step_q, step_d;
	uword_t uw;
	logic   jump;

	logic                  at_root_q, chk_q;
	logic [NODE_IDX_W-1:0] cur_q;
	logic [BYTE_W-1:0]     byte_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [ENTRY_W-1:0]    root_q, wr_entry, rd_entry, cur_entry;

	logic             pend_v_q, pend_err_q;
	logic [SYM_W-1:0] pend_sym_q;
	logic             out_v_q, out_last_q, out_err_q;
	logic [SYM_W-1:0] out_sym_q;

	logic                  in_acc, dec_acc, wr_acc, wr_ok;
	logic                  e_leaf, cur_bit, child_bad;
	logic [NODE_IDX_W-1:0] child;
	logic                  rd_leaf, bit_go, bit_err, step_rd;
	logic                  res_v;
	logic [SYM_W-1:0]      res_sym;
	logic                  out_busy, stall, walk_go, flush_go, walk_done;
	logic                  load_pend, load_out_mid;
	logic [CNT_W-1:0]      cnt_init;

	// Control word decode.
	always_comb begin
		uw = ucode_rom(step_q);
	end

	// Input handshake and table write.
	assign code.ready = uw.take_item;
	assign in_acc     = code.valid & uw.take_item;
	assign dec_acc    = in_acc & code.mode;
	assign wr_acc     = in_acc & ~code.mode;
	assign wr_ok      = int'(code.node_index) < NODE_COUNT;
	assign wr_entry   = {code.left_child, code.right_child, code.is_leaf,
		SYMBOL_BITS'(code.leaf_symbol)};
	assign cnt_init   = (code.bits_used > BITS_MAX) ? BITS_MAX : code.bits_used;

	// Current node entry and the step taken by the next code bit.
	assign cur_entry = at_root_q ? root_q : rd_entry;
	assign e_leaf    = cur_entry[LEAF_BIT];
	assign cur_bit   = byte_q[BYTE_W-1];
	assign child     = cur_bit ? cur_entry[RIGHT_LSB +: NODE_IDX_W]
		: cur_entry[LEFT_LSB +: NODE_IDX_W];
	assign child_bad = (child == NULL_CHILD) || (int'(child) >= NODE_COUNT);

	// A child read last cycle is checked for a leaf before the next bit is used.
	assign rd_leaf = uw.walk & chk_q & rd_entry[LEAF_BIT];
	assign bit_go  = uw.walk & ~rd_leaf & (cnt_q != '0);
	assign bit_err = bit_go & (e_leaf | child_bad);
	assign step_rd = bit_go & ~e_leaf & ~child_bad;

	assign res_v   = rd_leaf | bit_err;
	assign res_sym = rd_leaf ? SYM_W'(rd_entry[SYMBOL_BITS-1:0]) : '0;

	// A new result pushes the held one out; it waits if the output is full.
	assign out_busy     = out_v_q & ~result.ready;
	assign stall        = res_v & pend_v_q & out_busy;
	assign walk_go      = uw.walk & ~stall;
	assign flush_go     = uw.flush & pend_v_q & ~out_busy;
	assign walk_done    = (cnt_q == '0) & ~chk_q;
	assign load_pend    = walk_go & res_v;
	assign load_out_mid = load_pend & pend_v_q;

	// Node table.
	htd_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (NODE_COUNT)
	) u_table (
		.clk   (clk),
		.we    (wr_acc & wr_ok),
		.waddr (AW'(code.node_index)),
		.wdata (wr_entry),
		.re    (dec_acc | (walk_go & step_rd)),
		.raddr (dec_acc ? AW'(cur_q) : AW'(child)),
		.rdata (rd_entry)
	);

	// Sequencer next step.
	always_comb begin
		case (uw.jmp)
			JMP_ON_DECODE:  jump = dec_acc;
			JMP_ON_DONE:    jump = walk_done;
			JMP_ON_FLUSHED: jump = ~pend_v_q | ~out_busy;
			JMP_ALWAYS:     jump = 1'b1;
			default:        jump = 1'b0;
		endcase
		step_d = jump ? uw.target : step_q;
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q    <= STEP_FETCH;
			at_root_q <= 1'b1;
			chk_q     <= 1'b0;
			cur_q     <= '0;
			cnt_q     <= '0;
			pend_v_q  <= 1'b0;
			out_v_q   <= 1'b0;
		end else begin
			step_q <= step_d;
			if (dec_acc) begin
				cnt_q <= cnt_init;
			end
			if (walk_go) begin
				chk_q <= step_rd;
				if (bit_go) begin
					cnt_q <= cnt_q - 1'b1;
				end
				if (rd_leaf | bit_err) begin
					at_root_q <= 1'b1;
					cur_q     <= '0;
				end
				if (step_rd) begin
					at_root_q <= 1'b0;
					cur_q     <= child;
				end
			end
			// The output register is refilled from the held result or emptied when taken.
			if (load_out_mid | flush_go) begin
				out_v_q <= 1'b1;
			end else if (result.valid & result.ready) begin
				out_v_q <= 1'b0;
			end
			if (load_pend) begin
				pend_v_q <= 1'b1;
			end else if (flush_go) begin
				pend_v_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (wr_acc && (code.node_index == NULL_CHILD)) begin
			root_q <= wr_entry;
		end
		if (dec_acc) begin
			byte_q <= code.code_byte;
		end else if (walk_go & bit_go) begin
			byte_q <= byte_q << 1;
		end
		if (load_pend) begin
			pend_sym_q <= res_sym;
			pend_err_q <= ~rd_leaf;
		end
		if (load_out_mid) begin
			out_sym_q  <= pend_sym_q;
			out_err_q  <= pend_err_q;
			out_last_q <= 1'b0;
		end else if (flush_go) begin
			out_sym_q  <= pend_sym_q;
			out_err_q  <= pend_err_q;
			out_last_q <= 1'b1;
		end
	end

	// Result channel.
	assign result.valid  = out_v_q;
	assign result.symbol = out_sym_q;
	assign result.last   = out_last_q;
	assign result.error  = out_err_q;

endmodule

// ===== hdl/htd_checker.sv =====
// Port-level checker for the Huffman decoder core and its bind statement.
`include "huffman_tree_decoder_core_defines.svh"

module htd_checker import htd_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             code_valid,
	input logic             code_ready,
	input logic             code_mode,
	input logic             result_valid,
	input logic             result_ready,
	input logic [SYM_W-1:0] result_symbol,
	input logic             result_last,
	input logic             result_error
);

	// An error result carries a zero symbol.
	`HTD_ASSERT_IMPLY(a_err_sym_zero, result_valid && result_error, result_symbol == '0, "error result with nonzero symbol")

	// While items are taken, only the final result of the previous item may still wait.
	`HTD_ASSERT_IMPLY(a_idle_only_last, result_valid && code_ready, result_last, "non-final result left while idle")

	// A decode item keeps the block busy on the next cycle.
	`HTD_ASSERT_NEXT(a_decode_busy, code_valid && code_ready && code_mode, !code_ready, "ready after decode item")

	// A table write item leaves the input ready on the next cycle.
	`HTD_ASSERT_NEXT(a_write_one_cycle, code_valid && code_ready && !code_mode, code_ready, "ready dropped after table write")

	// A stalled result holds.
	`HTD_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(result_symbol) && $stable(result_last) && $stable(result_error), "stalled result changed")

endmodule

bind huffman_tree_decoder_core htd_checker u_htd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.code_valid    (code.valid),
	.code_ready    (code.ready),
	.code_mode     (code.mode),
	.result_valid  (result.valid),
	.result_ready  (result.ready),
	.result_symbol (result.symbol),
	.result_last   (result.last),
	.result_error  (result.error)
);
